>>> hdl/lcs_pkg.sv
// shared types and constants for the link connect supervisor
// no dependencies
package lcs_pkg;

    localparam int unsigned CfgWidth   = 31;
    localparam int unsigned TimeWidth  = 32;
    localparam int unsigned AddrWidth  = 4;
    localparam int unsigned DataWidth  = 32;
    localparam int unsigned ModeWidth  = 3;

    localparam logic [CfgWidth-1:0] ConnectTimeoutDefault = CfgWidth'(20 * 1000);
    localparam logic [CfgWidth-1:0] RetryIntervalDefault  = CfgWidth'(60 * 1000);
    localparam logic [CfgWidth-1:0] ApLingerDefault       = CfgWidth'(5 * 1000);
    localparam logic [CfgWidth-1:0] ApTimeoutDefault      = CfgWidth'(10 * 60 * 1000);

    // operation codes
    localparam logic [1:0] OP_POLL      = 2'd0;
    localparam logic [1:0] OP_START     = 2'd1;
    localparam logic [1:0] OP_RECONNECT = 2'd2;
    localparam logic [1:0] OP_NEW_CRED  = 2'd3;

    // register indexes
    localparam logic [1:0] REG_CONNECT_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_RETRY_INTERVAL  = 2'd1;
    localparam logic [1:0] REG_AP_LINGER       = 2'd2;
    localparam logic [1:0] REG_AP_TIMEOUT      = 2'd3;

    // reported mode codes
    localparam logic [ModeWidth-1:0] MODE_CODE_IDLE       = 3'd0;
    localparam logic [ModeWidth-1:0] MODE_CODE_CONNECTING = 3'd1;
    localparam logic [ModeWidth-1:0] MODE_CODE_ONLINE     = 3'd2;
    localparam logic [ModeWidth-1:0] MODE_CODE_RETRY      = 3'd3;
    localparam logic [ModeWidth-1:0] MODE_CODE_PORTAL     = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE       = 5'b00001,
        S_CONNECTING = 5'b00010,
        S_ONLINE     = 5'b00100,
        S_RETRY      = 5'b01000,
        S_PORTAL     = 5'b10000
    } t_mode;

    function automatic logic [ModeWidth-1:0] mode_code(input t_mode m);
        logic [ModeWidth-1:0] c;
        case (m)
            S_IDLE:       c = MODE_CODE_IDLE;
            S_CONNECTING: c = MODE_CODE_CONNECTING;
            S_ONLINE:     c = MODE_CODE_ONLINE;
            S_RETRY:      c = MODE_CODE_RETRY;
            S_PORTAL:     c = MODE_CODE_PORTAL;
            default:      c = MODE_CODE_IDLE;
        endcase
        return c;
    endfunction

    // wrap-safe deadline check: due when (now - deadline) is not negative
    function automatic logic is_due(input logic [TimeWidth-1:0] now,
                                    input logic [TimeWidth-1:0] deadline);
        logic [TimeWidth-1:0] diff;
        diff = now - deadline;
        return ~diff[TimeWidth-1];
    endfunction

endpackage

>>> hdl/link_connect_supervisor.sv
// link connect supervisor top level: input register, decision logic, result register
// depends on lcs_pkg
//
// usage
//   input channel i_in_valid / o_in_ready carries one word: operation, time in ms,
//   link status and the credential flags
//   output channel o_out_valid / i_out_ready carries one result word per input word:
//   mode, access point state, connect/drop/raise/lower commands and acceptance
//   the single decision stage sits between the two registers; one word per cycle is
//   sustained while the receiver takes each result word without stalling
//   the decision stage reads and updates the mode, flags and four deadlines, so each
//   word sees the state left by the word before it
//   when the receiver stalls the result register holds, the input register fills,
//   and o_in_ready drops until the result is taken
//   timeouts are set through the APB-style port (4-byte spaced registers, pready tied
//   high); user must keep them written only while the block is idle; not enforced
//   reset (synchronous, active low) empties both registers, puts the mode to idle,
//   clears flags and deadlines and loads the default timeouts
module link_connect_supervisor #(
    parameter logic [lcs_pkg::CfgWidth-1:0] P_CONNECT_TIMEOUT = lcs_pkg::ConnectTimeoutDefault,
    parameter logic [lcs_pkg::CfgWidth-1:0] P_RETRY_INTERVAL  = lcs_pkg::RetryIntervalDefault,
    parameter logic [lcs_pkg::CfgWidth-1:0] P_AP_LINGER       = lcs_pkg::ApLingerDefault,
    parameter logic [lcs_pkg::CfgWidth-1:0] P_AP_TIMEOUT      = lcs_pkg::ApTimeoutDefault
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lcs_pkg::AddrWidth-1:0]     paddr,
    input  logic [lcs_pkg::DataWidth-1:0]     pwdata,
    output logic [lcs_pkg::DataWidth-1:0]     prdata,
    output logic                              pready,

    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_operation,
    input  logic [lcs_pkg::TimeWidth-1:0]     i_now_ms,
    input  logic                              i_link_up,
    input  logic                              i_have_credentials,
    input  logic                              i_name_given,
    input  logic                              i_store_ok,

    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [lcs_pkg::ModeWidth-1:0]     o_link_mode,
    output logic                              o_ap_active,
    output logic                              o_begin_connect,
    output logic                              o_drop_station,
    output logic                              o_raise_ap,
    output logic                              o_lower_ap,
    output logic                              o_accepted
);
    import lcs_pkg::*;

    // configuration
    logic [CfgWidth-1:0]  r_connect_timeout;
    logic [CfgWidth-1:0]  r_retry_interval;
    logic [CfgWidth-1:0]  r_ap_linger;
    logic [CfgWidth-1:0]  r_ap_timeout;
    logic                 cfg_write;
    logic [1:0]           cfg_index;

    // input register
    logic                 r_in_valid;
    logic [1:0]           r_operation;
    logic [TimeWidth-1:0] r_now;
    logic                 r_link_up;
    logic                 r_have_cred;
    logic                 r_name_given;
    logic                 r_store_ok;

    // supervisor state
    t_mode                r_mode, n_mode;
    logic                 r_ap_up, n_ap_up;
    logic                 r_spent, n_spent;
    logic                 r_name_held, n_name_held;
    logic [TimeWidth-1:0] r_connect_due, n_connect_due;
    logic [TimeWidth-1:0] r_retry_due, n_retry_due;
    logic [TimeWidth-1:0] r_ap_due, n_ap_due;
    logic [TimeWidth-1:0] r_linger_due, n_linger_due;

    // result register
    logic                 r_out_valid;
    logic [ModeWidth-1:0] r_link_mode;
    logic                 r_ap_active;
    logic                 r_begin, r_drop, r_raise, r_lower, r_accepted;

    logic                 n_begin, n_drop, n_raise, n_lower, n_accepted;
    logic                 advance;
    logic                 in_take;
    logic [TimeWidth-1:0] sum_connect, sum_retry, sum_linger, sum_ap;

    assign cfg_write = psel & penable & pwrite;
    assign cfg_index = paddr[AddrWidth-1:2];
    assign pready    = 1'b1;

    always_comb begin
        case (cfg_index)
            REG_CONNECT_TIMEOUT: prdata = DataWidth'(r_connect_timeout);
            REG_RETRY_INTERVAL:  prdata = DataWidth'(r_retry_interval);
            REG_AP_LINGER:       prdata = DataWidth'(r_ap_linger);
            REG_AP_TIMEOUT:      prdata = DataWidth'(r_ap_timeout);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_connect_timeout <= P_CONNECT_TIMEOUT;
            r_retry_interval  <= P_RETRY_INTERVAL;
            r_ap_linger       <= P_AP_LINGER;
            r_ap_timeout      <= P_AP_TIMEOUT;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_CONNECT_TIMEOUT: r_connect_timeout <= pwdata[CfgWidth-1:0];
                REG_RETRY_INTERVAL:  r_retry_interval  <= pwdata[CfgWidth-1:0];
                REG_AP_LINGER:       r_ap_linger       <= pwdata[CfgWidth-1:0];
                REG_AP_TIMEOUT:      r_ap_timeout      <= pwdata[CfgWidth-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign advance    = ~r_out_valid | i_out_ready;
    assign o_in_ready = ~r_in_valid | advance;
    assign in_take    = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_operation  <= i_operation;
            r_now        <= i_now_ms;
            r_link_up    <= i_link_up;
            r_have_cred  <= i_have_credentials;
            r_name_given <= i_name_given;
            r_store_ok   <= i_store_ok;
        end
    end

    assign sum_connect = r_now + TimeWidth'(r_connect_timeout);
    assign sum_retry   = r_now + TimeWidth'(r_retry_interval);
    assign sum_linger  = r_now + TimeWidth'(r_ap_linger);
    assign sum_ap      = r_now + TimeWidth'(r_ap_timeout);

    // decision logic
    always_comb begin
        n_mode        = r_mode;
        n_ap_up       = r_ap_up;
        n_spent       = r_spent;
        n_name_held   = r_name_held;
        n_connect_due = r_connect_due;
        n_retry_due   = r_retry_due;
        n_ap_due      = r_ap_due;
        n_linger_due  = r_linger_due;
        n_begin       = 1'b0;
        n_drop        = 1'b0;
        n_raise       = 1'b0;
        n_lower       = 1'b0;
        n_accepted    = 1'b0;

        case (r_operation)
            OP_POLL: begin
                case (r_mode)
                    S_CONNECTING: begin
                        if (r_link_up) begin
                            n_mode       = S_ONLINE;
                            n_linger_due = sum_linger;
                            n_spent      = 1'b0;
                        end else if (is_due(r_now, r_connect_due)) begin
                            n_drop      = 1'b1;
                            n_mode      = S_RETRY;
                            n_retry_due = sum_retry;
                            if (!r_spent) begin
                                n_spent = 1'b1;
                                if (!r_ap_up) begin
                                    n_ap_up  = 1'b1;
                                    n_ap_due = sum_ap;
                                    n_raise  = 1'b1;
                                end
                            end
                        end
                    end
                    S_ONLINE: begin
                        if (!r_link_up) begin
                            n_mode      = S_RETRY;
                            n_retry_due = sum_retry;
                            if (!r_spent) begin
                                n_spent = 1'b1;
                                if (!r_ap_up) begin
                                    n_ap_up  = 1'b1;
                                    n_ap_due = sum_ap;
                                    n_raise  = 1'b1;
                                end
                            end
                        end else if (r_ap_up && is_due(r_now, r_linger_due)) begin
                            n_ap_up = 1'b0;
                            n_lower = 1'b1;
                        end
                    end
                    S_RETRY: begin
                        if (r_ap_up && is_due(r_now, r_ap_due)) begin
                            n_ap_up = 1'b0;
                            n_lower = 1'b1;
                        end
                        if (is_due(r_now, r_retry_due)) begin
                            n_mode        = S_CONNECTING;
                            n_connect_due = sum_connect;
                            n_begin       = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_START: begin
                n_name_held = r_have_cred;
                if (r_have_cred) begin
                    n_mode        = S_CONNECTING;
                    n_connect_due = sum_connect;
                    n_begin       = 1'b1;
                end else begin
                    if (!r_ap_up) begin
                        n_ap_up  = 1'b1;
                        n_ap_due = sum_ap;
                        n_raise  = 1'b1;
                    end
                    n_spent = 1'b1;
                    n_mode  = S_PORTAL;
                end
            end
            OP_RECONNECT: begin
                if (r_name_held) begin
                    n_mode        = S_CONNECTING;
                    n_connect_due = sum_connect;
                    n_begin       = 1'b1;
                end
            end
            OP_NEW_CRED: begin
                if (r_name_given) begin
                    n_name_held = 1'b1;
                    if (r_store_ok) begin
                        n_spent       = 1'b1;
                        n_mode        = S_CONNECTING;
                        n_connect_due = sum_connect;
                        n_begin       = 1'b1;
                        n_accepted    = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= S_IDLE;
            r_ap_up       <= 1'b0;
            r_spent       <= 1'b0;
            r_name_held   <= 1'b0;
            r_connect_due <= '0;
            r_retry_due   <= '0;
            r_ap_due      <= '0;
            r_linger_due  <= '0;
        end else if (r_in_valid && advance) begin
            r_mode        <= n_mode;
            r_ap_up       <= n_ap_up;
            r_spent       <= n_spent;
            r_name_held   <= n_name_held;
            r_connect_due <= n_connect_due;
            r_retry_due   <= n_retry_due;
            r_ap_due      <= n_ap_due;
            r_linger_due  <= n_linger_due;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_link_mode <= mode_code(n_mode);
            r_ap_active <= n_ap_up;
            r_begin     <= n_begin;
            r_drop      <= n_drop;
            r_raise     <= n_raise;
            r_lower     <= n_lower;
            r_accepted  <= n_accepted;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_link_mode     = r_link_mode;
    assign o_ap_active     = r_ap_active;
    assign o_begin_connect = r_begin;
    assign o_drop_station  = r_drop;
    assign o_raise_ap      = r_raise;
    assign o_lower_ap      = r_lower;
    assign o_accepted      = r_accepted;

endmodule

>>> tb/sv/lcs_result_checker.sv
`timescale 1ns / 100ps
// result checker for the link connect supervisor: follows apb timeout writes, predicts one
// result word per accepted input word and compares the result channel field by field
// depends on lcs_pkg
module lcs_result_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [lcs_pkg::AddrWidth-1:0] i_paddr,
    input  logic [lcs_pkg::DataWidth-1:0] i_pwdata,
    input  logic                          i_pready,

    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [1:0]                    i_operation,
    input  logic [lcs_pkg::TimeWidth-1:0] i_now_ms,
    input  logic                          i_link_up,
    input  logic                          i_have_credentials,
    input  logic                          i_name_given,
    input  logic                          i_store_ok,

    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [lcs_pkg::ModeWidth-1:0] i_link_mode,
    input  logic                          i_ap_active,
    input  logic                          i_begin_connect,
    input  logic                          i_drop_station,
    input  logic                          i_raise_ap,
    input  logic                          i_lower_ap,
    input  logic                          i_accepted,

    output int                            o_mismatches,
    output int                            o_pending,
    output int                            o_checked
);
    import lcs_pkg::*;

    typedef struct packed {
        logic [ModeWidth-1:0] link_mode;
        logic                 ap_active;
        logic                 begin_connect;
        logic                 drop_station;
        logic                 raise_ap;
        logic                 lower_ap;
        logic                 accepted;
    } t_link_result;

    logic [TimeWidth-1:0] connect_timeout;
    logic [TimeWidth-1:0] retry_interval;
    logic [TimeWidth-1:0] ap_linger;
    logic [TimeWidth-1:0] ap_lifetime;

    logic [ModeWidth-1:0] link_mode;
    logic                 ap_up;
    logic                 window_spent;
    logic                 name_known;
    logic [TimeWidth-1:0] attempt_deadline;
    logic [TimeWidth-1:0] retry_deadline;
    logic [TimeWidth-1:0] ap_deadline;
    logic [TimeWidth-1:0] linger_deadline;

    t_link_result expected_results[$];
    t_link_result want;
    t_link_result got;

    int mismatch_count = 0;
    int pending_count  = 0;
    int checked_count  = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;
    assign o_checked    = checked_count;

    function automatic logic deadline_passed(input logic [TimeWidth-1:0] now,
                                             input logic [TimeWidth-1:0] deadline);
        logic [TimeWidth-1:0] lag;
        lag = now - deadline;
        return $signed(lag) >= 0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        if (mismatch_count < 40) begin
            $display("[%0t] result word %0d: %s expected %0d got %0d",
                     $time, checked_count, what, want_v, got_v);
        end
        mismatch_count++;
    endtask

    task automatic bring_ap_up(input logic [TimeWidth-1:0] now, inout t_link_result r);
        if (!ap_up) begin
            ap_up       = 1'b1;
            ap_deadline = now + ap_lifetime;
            r.raise_ap  = 1'b1;
        end
    endtask

    task automatic take_ap_down(inout t_link_result r);
        if (ap_up) begin
            ap_up      = 1'b0;
            r.lower_ap = 1'b1;
        end
    endtask

    task automatic begin_attempt(input logic [TimeWidth-1:0] now, inout t_link_result r);
        link_mode        = MODE_CODE_CONNECTING;
        attempt_deadline = now + connect_timeout;
        r.begin_connect  = 1'b1;
    endtask

    task automatic go_offline(input logic [TimeWidth-1:0] now, inout t_link_result r);
        link_mode      = MODE_CODE_RETRY;
        retry_deadline = now + retry_interval;
        if (!window_spent) begin
            bring_ap_up(now, r);
            window_spent = 1'b1;
        end
    endtask

    task automatic step_supervisor(input logic [1:0] op, input logic [TimeWidth-1:0] now,
                                   input logic link, input logic have, input logic named,
                                   input logic stored, output t_link_result r);
        r = '0;
        case (op)
            OP_POLL: begin
                if (link_mode == MODE_CODE_CONNECTING) begin
                    if (link) begin
                        link_mode       = MODE_CODE_ONLINE;
                        linger_deadline = now + ap_linger;
                        window_spent    = 1'b0;
                    end else if (deadline_passed(now, attempt_deadline)) begin
                        r.drop_station = 1'b1;
                        go_offline(now, r);
                    end
                end else if (link_mode == MODE_CODE_ONLINE) begin
                    if (!link) begin
                        go_offline(now, r);
                    end else if (ap_up && deadline_passed(now, linger_deadline)) begin
                        take_ap_down(r);
                    end
                end else if (link_mode == MODE_CODE_RETRY) begin
                    if (ap_up && deadline_passed(now, ap_deadline)) begin
                        take_ap_down(r);
                    end
                    if (deadline_passed(now, retry_deadline)) begin
                        begin_attempt(now, r);
                    end
                end
            end
            OP_START: begin
                name_known = have;
                if (have) begin
                    begin_attempt(now, r);
                end else begin
                    bring_ap_up(now, r);
                    window_spent = 1'b1;
                    link_mode    = MODE_CODE_PORTAL;
                end
            end
            OP_RECONNECT: begin
                if (name_known) begin
                    begin_attempt(now, r);
                end
            end
            OP_NEW_CRED: begin
                if (named) begin
                    name_known = 1'b1;
                    if (stored) begin
                        window_spent = 1'b1;
                        begin_attempt(now, r);
                        r.accepted = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.link_mode = link_mode;
        r.ap_active = ap_up;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            connect_timeout  = {1'b0, ConnectTimeoutDefault};
            retry_interval   = {1'b0, RetryIntervalDefault};
            ap_linger        = {1'b0, ApLingerDefault};
            ap_lifetime      = {1'b0, ApTimeoutDefault};
            link_mode        = MODE_CODE_IDLE;
            ap_up            = 1'b0;
            window_spent     = 1'b0;
            name_known       = 1'b0;
            attempt_deadline = '0;
            retry_deadline   = '0;
            ap_deadline      = '0;
            linger_deadline  = '0;
            expected_results.delete();
            pending_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_CONNECT_TIMEOUT: connect_timeout = {1'b0, i_pwdata[CfgWidth-1:0]};
                    REG_RETRY_INTERVAL:  retry_interval  = {1'b0, i_pwdata[CfgWidth-1:0]};
                    REG_AP_LINGER:       ap_linger       = {1'b0, i_pwdata[CfgWidth-1:0]};
                    REG_AP_TIMEOUT:      ap_lifetime     = {1'b0, i_pwdata[CfgWidth-1:0]};
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.link_mode     = i_link_mode;
                got.ap_active     = i_ap_active;
                got.begin_connect = i_begin_connect;
                got.drop_station  = i_drop_station;
                got.raise_ap      = i_raise_ap;
                got.lower_ap      = i_lower_ap;
                got.accepted      = i_accepted;
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with nothing expected, mode", 32'd0,
                                    32'(got.link_mode));
                end else begin
                    want = expected_results.pop_front();
                    if (got.link_mode !== want.link_mode)
                        report_mismatch("link_mode", 32'(want.link_mode),
                                        32'(got.link_mode));
                    if (got.ap_active !== want.ap_active)
                        report_mismatch("ap_active", 32'(want.ap_active),
                                        32'(got.ap_active));
                    if (got.begin_connect !== want.begin_connect)
                        report_mismatch("begin_connect", 32'(want.begin_connect),
                                        32'(got.begin_connect));
                    if (got.drop_station !== want.drop_station)
                        report_mismatch("drop_station", 32'(want.drop_station),
                                        32'(got.drop_station));
                    if (got.raise_ap !== want.raise_ap)
                        report_mismatch("raise_ap", 32'(want.raise_ap),
                                        32'(got.raise_ap));
                    if (got.lower_ap !== want.lower_ap)
                        report_mismatch("lower_ap", 32'(want.lower_ap),
                                        32'(got.lower_ap));
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", 32'(want.accepted),
                                        32'(got.accepted));
                    checked_count++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                step_supervisor(i_operation, i_now_ms, i_link_up, i_have_credentials,
                                i_name_given, i_store_ok, want);
                expected_results.push_back(want);
            end
            pending_count = expected_results.size();
        end
    end

endmodule

>>> tb/sv/link_connect_supervisor_tb.sv
`timescale 1ns / 100ps
// testbench top for the link connect supervisor: clock, reset, apb timeout writes,
// directed and random operation words, random result back-pressure and the verdict
// depends on lcs_pkg, link_connect_supervisor and lcs_result_checker
module link_connect_supervisor_tb;
    import lcs_pkg::*;

    localparam int RunLimitCycles = 900000;
    localparam int DrainCycles    = 8;
    localparam int WordsPerPhase  = 280;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [AddrWidth-1:0] paddr = '0;
    logic [DataWidth-1:0] pwdata = '0;
    logic [DataWidth-1:0] prdata;
    logic                 pready;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           operation = OP_POLL;
    logic [TimeWidth-1:0] now_ms = '0;
    logic                 link_up = 1'b0;
    logic                 have_credentials = 1'b0;
    logic                 name_given = 1'b0;
    logic                 store_ok = 1'b0;

    logic                 out_valid;
    logic                 out_ready = 1'b1;
    logic [ModeWidth-1:0] link_mode;
    logic                 ap_active;
    logic                 begin_connect;
    logic                 drop_station;
    logic                 raise_ap;
    logic                 lower_ap;
    logic                 accepted;

    int mismatch_total;
    int pending_words;
    int checked_words;

    logic [TimeWidth-1:0] wall_ms = '0;
    logic [31:0]          cfg_value [4];
    logic [31:0]          cfg_scale = 32'd600000;
    int                   ops_sent [4] = '{0, 0, 0, 0};
    int                   words_sent = 0;
    int                   settings_applied = 0;
    int                   steady_words = 0;
    int                   cycle_count = 0;

    always #5 clk = ~clk;

    link_connect_supervisor u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_operation        (operation),
        .i_now_ms           (now_ms),
        .i_link_up          (link_up),
        .i_have_credentials (have_credentials),
        .i_name_given       (name_given),
        .i_store_ok         (store_ok),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_link_mode        (link_mode),
        .o_ap_active        (ap_active),
        .o_begin_connect    (begin_connect),
        .o_drop_station     (drop_station),
        .o_raise_ap         (raise_ap),
        .o_lower_ap         (lower_ap),
        .o_accepted         (accepted)
    );

    lcs_result_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .i_pready           (pready),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_operation        (operation),
        .i_now_ms           (now_ms),
        .i_link_up          (link_up),
        .i_have_credentials (have_credentials),
        .i_name_given       (name_given),
        .i_store_ok         (store_ok),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_link_mode        (link_mode),
        .i_ap_active        (ap_active),
        .i_begin_connect    (begin_connect),
        .i_drop_station     (drop_station),
        .i_raise_ap         (raise_ap),
        .i_lower_ap         (lower_ap),
        .i_accepted         (accepted),
        .o_mismatches       (mismatch_total),
        .o_pending          (pending_words),
        .o_checked          (checked_words)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [31:0] pick_timeout(input logic allow_zero);
        int          r;
        logic [31:0] v;
        r = $urandom_range(0, 99);
        if (r < 45) v = $urandom_range(1, 64);
        else if (r < 75) v = $urandom_range(1, 5000);
        else if (r < 93) v = $urandom_range(1, 1 << 20);
        else v = $urandom_range(1, 32'h7FFF_FFFF);
        if (allow_zero && $urandom_range(0, 5) == 0) v = '0;
        return v;
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [TimeWidth-1:0] now,
                             input logic link, input logic have, input logic named,
                             input logic stored);
        int gap;
        gap = (steady_words > 0) ? 0 : pick_gap();
        if (steady_words > 0) steady_words--;
        else if ($urandom_range(0, 99) == 0) steady_words = $urandom_range(30, 80);
        if (gap > 0) begin
            @(negedge clk);
            in_valid         <= 1'b0;
            operation        <= 2'($urandom);
            now_ms           <= $urandom;
            link_up          <= 1'($urandom);
            have_credentials <= 1'($urandom);
            name_given       <= 1'($urandom);
            store_ok         <= 1'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid         <= 1'b1;
        operation        <= op;
        now_ms           <= now;
        link_up          <= link;
        have_credentials <= have;
        name_given       <= named;
        store_ok         <= stored;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ops_sent[op]++;
        words_sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_words != 0) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [1:0] reg_index, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_timeouts(input logic [31:0] conn, input logic [31:0] retry,
                                  input logic [31:0] linger, input logic [31:0] ap_life);
        hold_until_drained();
        repeat (DrainCycles) @(negedge clk);
        write_timeout(REG_CONNECT_TIMEOUT, conn);
        write_timeout(REG_RETRY_INTERVAL, retry);
        write_timeout(REG_AP_LINGER, linger);
        write_timeout(REG_AP_TIMEOUT, ap_life);
        cfg_value[REG_CONNECT_TIMEOUT] = conn & 32'h7FFF_FFFF;
        cfg_value[REG_RETRY_INTERVAL]  = retry & 32'h7FFF_FFFF;
        cfg_value[REG_AP_LINGER]       = linger & 32'h7FFF_FFFF;
        cfg_value[REG_AP_TIMEOUT]      = ap_life & 32'h7FFF_FFFF;
        cfg_scale = 32'd1;
        for (int k = 0; k < 4; k++) begin
            if (cfg_value[k] > cfg_scale) cfg_scale = cfg_value[k];
        end
        settings_applied++;
    endtask

    task automatic advance_wall_clock();
        int          r;
        logic [31:0] delta;
        r = $urandom_range(0, 99);
        if (r < 30) delta = $urandom_range(0, 3);
        else if (r < 65) delta = $urandom_range(0, cfg_scale);
        else if (r < 85) delta = cfg_value[$urandom_range(0, 3)] + $urandom_range(0, 2) - 1;
        else if (r < 95) delta = $urandom;
        else delta = -$urandom_range(1, 64);
        wall_ms = wall_ms + delta;
    endtask

    task automatic run_random_words(input int count);
        int         r;
        logic [1:0] op;
        for (int n = 0; n < count; n++) begin
            if (n == count / 3 || $urandom_range(0, 199) == 0) hold_until_drained();
            advance_wall_clock();
            r = $urandom_range(0, 99);
            if (r < 62) op = OP_POLL;
            else if (r < 74) op = OP_START;
            else if (r < 86) op = OP_RECONNECT;
            else op = OP_NEW_CRED;
            send_word(op, wall_ms, 1'($urandom), $urandom_range(0, 3) != 0,
                      $urandom_range(0, 6) != 0, $urandom_range(0, 9) < 7);
        end
    endtask

    task automatic run_directed();
        send_word(OP_POLL,      32'd0,         1'b0, 1'b1, 1'b1, 1'b1);
        send_word(OP_RECONNECT, 32'd10,        1'b1, 1'b0, 1'b0, 1'b0);
        send_word(OP_NEW_CRED,  32'd20,        1'b1, 1'b1, 1'b0, 1'b1);
        send_word(OP_NEW_CRED,  32'd30,        1'b0, 1'b0, 1'b1, 1'b0);
        send_word(OP_RECONNECT, 32'd100,       1'b0, 1'b0, 1'b0, 1'b0);
        send_word(OP_POLL,      32'd20099,     1'b0, 1'b0, 1'b0, 1'b0);
        send_word(OP_POLL,      32'd20100,     1'b0, 1'b0, 1'b0, 1'b0);
        send_word(OP_POLL,      32'd80099,     1'b0, 1'b1, 1'b1, 1'b1);
        send_word(OP_POLL,      32'd80100,     1'b0, 1'b0, 1'b0, 1'b0);
        send_word(OP_POLL,      32'd80200,     1'b1, 1'b0, 1'b0, 1'b0);
        send_word(OP_POLL,      32'd85199,     1'b1, 1'b0, 1'b0, 1'b0);
        send_word(OP_POLL,      32'd85200,     1'b1, 1'b0, 1'b0, 1'b0);
        send_word(OP_POLL,      32'd90000,     1'b0, 1'b0, 1'b0, 1'b0);
        // access point lifetime and retry both due on one poll
        send_word(OP_POLL,      32'd690000,    1'b0, 1'b0, 1'b0, 1'b0);
        send_word(OP_START,     32'd700000,    1'b1, 1'b0, 1'b1, 1'b1);
        send_word(OP_POLL,      32'd800000,    1'b1, 1'b0, 1'b0, 1'b0);
        send_word(OP_NEW_CRED,  32'd800010,    1'b0, 1'b0, 1'b1, 1'b1);
        // connect deadline wraps past zero
        send_word(OP_START,     32'hFFFF_F000, 1'b0, 1'b1, 1'b0, 1'b0);
        send_word(OP_POLL,      32'h0000_0010, 1'b0, 1'b0, 1'b0, 1'b0);
        send_word(OP_POLL,      32'h0000_3E20, 1'b0, 1'b0, 1'b0, 1'b0);
        send_word(OP_POLL,      32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(OP_RECONNECT, 32'h8000_0000, 1'b1, 1'b1, 1'b1, 1'b1);
        wall_ms = 32'h8000_0000;
    endtask

    initial begin
        int stall;
        int run;
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 6);
            repeat (run - 1) @(negedge clk);
        end
    end

    initial begin
        while (cycle_count < RunLimitCycles) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words still expected", cycle_count,
                 pending_words);
        $display("link_connect_supervisor verification failed");
        $finish;
    end

    initial begin
        cfg_value[REG_CONNECT_TIMEOUT] = {1'b0, ConnectTimeoutDefault};
        cfg_value[REG_RETRY_INTERVAL]  = {1'b0, RetryIntervalDefault};
        cfg_value[REG_AP_LINGER]       = {1'b0, ApLingerDefault};
        cfg_value[REG_AP_TIMEOUT]      = {1'b0, ApTimeoutDefault};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        settings_applied = 1;
        run_directed();
        run_random_words(WordsPerPhase);

        apply_timeouts(32'd5, 32'd7, 32'd3, 32'd12);
        run_random_words(WordsPerPhase);
        apply_timeouts(32'd1, 32'd1, 32'd0, 32'd1);
        run_random_words(WordsPerPhase);
        apply_timeouts(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random_words(WordsPerPhase);
        apply_timeouts({1'b0, ConnectTimeoutDefault}, {1'b0, RetryIntervalDefault},
                       {1'b0, ApLingerDefault}, {1'b0, ApTimeoutDefault});
        run_random_words(WordsPerPhase);
        for (int p = 0; p < 2; p++) begin
            apply_timeouts(pick_timeout(1'b0), pick_timeout(1'b0), pick_timeout(1'b1),
                           pick_timeout(1'b0));
            run_random_words(WordsPerPhase);
        end

        hold_until_drained();
        repeat (DrainCycles) @(negedge clk);

        $display("covered %0d words: %0d poll, %0d start, %0d reconnect, %0d new credentials",
                 words_sent, ops_sent[OP_POLL], ops_sent[OP_START], ops_sent[OP_RECONNECT],
                 ops_sent[OP_NEW_CRED]);
        $display("across %0d timeout settings, %0d result words compared, %0d mismatches",
                 settings_applied, checked_words, mismatch_total);
        if (pending_words != 0) $display("%0d expected result words never arrived",
                                         pending_words);
        if (mismatch_total == 0 && pending_words == 0) begin
            $display("link_connect_supervisor verification clean");
        end else begin
            $display("link_connect_supervisor verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/lcs_pkg.sv
hdl/link_connect_supervisor.sv
tb/sv/lcs_result_checker.sv
tb/sv/link_connect_supervisor_tb.sv
